// ----- design/cpio_newc_stream_parser_unit_macros.svh -----
// Assertion macros shared by the parser modules.
`ifndef CPIO_NEWC_STREAM_PARSER_UNIT_MACROS_SVH
`define CPIO_NEWC_STREAM_PARSER_UNIT_MACROS_SVH

// Implication checked at every clock edge, outside reset.
`define CPIO_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must hold at every clock edge, outside reset.
`define CPIO_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

// ----- design/cpio_pkg.sv -----
// ----------------------------------------------------------------------------
// cpio_pkg
// Shared types and constants for the cpio newc stream parser.
// ----------------------------------------------------------------------------
package cpio_pkg;

	localparam int unsigned HdrLen = 110;
	localparam int unsigned QDepth = 4;
	localparam int unsigned QAw = 2;

	// result kinds
	localparam logic [1:0] KIND_NAME = 2'd0;
	localparam logic [1:0] KIND_REC  = 2'd1;
	localparam logic [1:0] KIND_DATA = 2'd2;
	localparam logic [1:0] KIND_END  = 2'd3;

	// one classified transaction handed from front to back
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  byte_value;
		logic        keep_entry;
		logic        run_last;
		logic [31:0] file_mode;
		logic [31:0] owner_id;
		logic [31:0] group_id;
		logic [31:0] data_length;
		logic [31:0] name_length;
		logic        bad_header;
	} res_t;

	// hex digit decode: bit 4 is the valid flag
	function automatic logic [4:0] hex_dec(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	// "TRAILER!!!" character by position
	function automatic logic [7:0] trailer_char(input logic [3:0] i);
		logic [7:0] r;
		case (i)
			4'd0: r = 8'h54;
			4'd1: r = 8'h52;
			4'd2: r = 8'h41;
			4'd3: r = 8'h49;
			4'd4: r = 8'h4C;
			4'd5: r = 8'h45;
			4'd6: r = 8'h52;
			default: r = 8'h21;
		endcase
		return r;
	endfunction

endpackage

// ----- design/cpio_front.sv -----
// ----------------------------------------------------------------------------
// cpio_front
// Stream front end: tracks archive phase, decodes the header and classifies
// each byte into at most one result transaction.
// ----------------------------------------------------------------------------
module cpio_front import cpio_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       res_valid,
	output res_t       res
);
	`include "cpio_newc_stream_parser_unit_macros.svh"

	typedef enum logic [2:0] {
		PH_HEADER, PH_NAME, PH_NAME_PAD, PH_DATA, PH_DATA_PAD, PH_DONE
	} phase_t;

	phase_t      phase_q;
	logic [31:0] count_q;
	logic [1:0]  align_q;
	logic [31:0] mode_q, uid_q, gid_q, size_q, nsize_q;
	logic        stop_q, bad_q, nul_q;
	logic [2:0]  match_q;

	phase_t      phase_d;
	logic [31:0] count_d;
	logic [1:0]  align_d;
	logic [31:0] mode_d, uid_d, gid_d, size_d, nsize_d;
	logic        stop_d, bad_d, nul_d;
	logic [2:0]  match_d;

	logic        emit;
	logic [1:0]  kind;
	logic        keep, last_flag;

	logic [6:0]  hp;
	logic [6:0]  rel;
	logic [3:0]  fld;
	logic [2:0]  dig;
	logic [4:0]  hx;
	logic        nlast, dlast;
	logic [2:0]  m_fin, m_upd;
	logic        trl_ok;

	assign hp    = count_q[6:0];
	assign rel   = hp - 7'd6;
	assign fld   = rel[6:3];
	assign dig   = rel[2:0];
	assign hx    = hex_dec(data_byte);
	assign nlast = (count_q == nsize_q - 32'd1);
	assign dlast = (count_q == size_q - 32'd1);
	assign trl_ok = (count_q < 32'd10) && (trailer_char(count_q[3:0]) == data_byte);

	// candidate match against ".", "..", "TRAILER!!!"
	always_comb begin
		m_fin = match_q;
		if (count_q != 32'd1)  m_fin[0] = 1'b0;
		if (count_q != 32'd2)  m_fin[1] = 1'b0;
		if (count_q != 32'd10) m_fin[2] = 1'b0;
		m_upd = match_q;
		if (!(count_q == 32'd0 && data_byte == 8'h2E)) m_upd[0] = 1'b0;
		if (!(count_q < 32'd2 && data_byte == 8'h2E))  m_upd[1] = 1'b0;
		if (!trl_ok) m_upd[2] = 1'b0;
	end

	// next-state and classification
	always_comb begin
		phase_d = phase_q; count_d = count_q; align_d = align_q + 2'd1;
		mode_d = mode_q; uid_d = uid_q; gid_d = gid_q;
		size_d = size_q; nsize_d = nsize_q;
		stop_d = stop_q; bad_d = bad_q; nul_d = nul_q; match_d = match_q;
		emit = 1'b0; kind = KIND_NAME; keep = 1'b1; last_flag = 1'b0;
		case (phase_q)
			PH_HEADER: begin
				if (hp == 7'd0) begin
					mode_d = '0; uid_d = '0; gid_d = '0; size_d = '0; nsize_d = '0;
					bad_d = 1'b0; stop_d = 1'b0;
				end
				if (hp >= 7'd6) begin
					if (dig == 3'd0) stop_d = 1'b0;
					if ((fld == 4'd1 || fld == 4'd2 || fld == 4'd3 || fld == 4'd6 ||
						fld == 4'd11) && !stop_d) begin
						if (!hx[4]) begin
							stop_d = 1'b1; bad_d = 1'b1;
						end else begin
							case (fld)
								4'd1: mode_d = {mode_q[27:0], hx[3:0]};
								4'd2: uid_d = {uid_q[27:0], hx[3:0]};
								4'd3: gid_d = {gid_q[27:0], hx[3:0]};
								4'd6: size_d = {size_q[27:0], hx[3:0]};
								default: nsize_d = {nsize_q[27:0], hx[3:0]};
							endcase
						end
					end
				end
				if (hp != 7'(HdrLen - 1)) begin
					count_d = count_q + 32'd1;
				end else begin
					count_d = '0; nul_d = 1'b0; match_d = 3'b111;
					if (nsize_d == 32'd0) begin
						// empty name: record right away
						match_d = 3'b000; nul_d = 1'b1; emit = 1'b1; kind = KIND_REC;
						if (align_d == 2'd0) phase_d = (size_d == 0) ? PH_HEADER : PH_DATA;
						else phase_d = PH_NAME_PAD;
					end else begin
						phase_d = PH_NAME;
					end
				end
			end
			PH_NAME: begin
				if (!nul_q) begin
					if (data_byte == 8'h00 || nlast) begin
						match_d = m_fin; nul_d = 1'b1; emit = 1'b1;
						kind = m_fin[2] ? KIND_END : KIND_REC;
						keep = m_fin[2] | ~(|m_fin[1:0]);
					end else begin
						match_d = m_upd; emit = 1'b1; kind = KIND_NAME;
						last_flag = (nsize_q >= 32'd2) && (count_q == nsize_q - 32'd2);
					end
				end
				if (nlast) begin
					count_d = '0;
					if (match_d[2]) phase_d = PH_DONE;
					else if (align_d == 2'd0) phase_d = (size_q == 0) ? PH_HEADER : PH_DATA;
					else phase_d = PH_NAME_PAD;
				end else begin
					count_d = count_q + 32'd1;
				end
			end
			PH_NAME_PAD: begin
				if (align_d == 2'd0) begin
					count_d = '0; phase_d = (size_q == 0) ? PH_HEADER : PH_DATA;
				end
			end
			PH_DATA: begin
				if (match_q[1:0] == 2'b00) begin
					emit = 1'b1; kind = KIND_DATA; last_flag = dlast;
				end
				if (dlast) begin
					count_d = '0; phase_d = (align_d == 2'd0) ? PH_HEADER : PH_DATA_PAD;
				end else begin
					count_d = count_q + 32'd1;
				end
			end
			PH_DATA_PAD: begin
				if (align_d == 2'd0) begin
					count_d = '0; phase_d = PH_HEADER;
				end
			end
			default: ;
		endcase
		if (final_byte) begin
			phase_d = PH_HEADER; count_d = '0; align_d = '0;
			stop_d = 1'b0; nul_d = 1'b0; match_d = 3'b111;
		end
	end

	// state registers and the front output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER; count_q <= '0; align_q <= '0;
			mode_q <= '0; uid_q <= '0; gid_q <= '0; size_q <= '0; nsize_q <= '0;
			stop_q <= 1'b0; bad_q <= 1'b0; nul_q <= 1'b0; match_q <= 3'b111;
			res_valid <= 1'b0;
		end else begin
			res_valid <= take & emit;
			if (take) begin
				phase_q <= phase_d; count_q <= count_d; align_q <= align_d;
				mode_q <= mode_d; uid_q <= uid_d; gid_q <= gid_d;
				size_q <= size_d; nsize_q <= nsize_d;
				stop_q <= stop_d; bad_q <= bad_d; nul_q <= nul_d; match_q <= match_d;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take && emit) begin
			res.kind <= kind;
			res.byte_value <= (kind == KIND_NAME || kind == KIND_DATA) ? data_byte : 8'd0;
			res.keep_entry <= keep;
			res.run_last <= last_flag;
			res.file_mode <= mode_d; res.owner_id <= uid_d; res.group_id <= gid_d;
			res.data_length <= size_d; res.name_length <= nsize_d;
			res.bad_header <= bad_d;
		end
	end

	`CPIO_ASSERT_IMPL(a_fin_reset, take && final_byte, ##1 (phase_q == PH_HEADER && count_q == 0), "final byte did not return to header start")
	`CPIO_ASSERT_IMPL(a_hdr_count, phase_q == PH_HEADER, count_q < 32'(HdrLen), "header count past header length")
	`CPIO_ASSERT_IMPL(a_done_quiet, take && phase_q == PH_DONE, ##1 !res_valid, "result after archive end")
endmodule

// ----- design/cpio_queue.sv -----
// ----------------------------------------------------------------------------
// cpio_queue
// Short result queue between the classifying front and the output back end.
// ----------------------------------------------------------------------------
module cpio_queue import cpio_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	input  logic pop,
	output logic not_empty,
	output logic room,
	output res_t head
);
	`include "cpio_newc_stream_parser_unit_macros.svh"

	res_t           mem_q [QDepth];
	logic [QAw-1:0] wr_q, rd_q;
	logic [QAw:0]   cnt_q;

	assign not_empty = (cnt_q != '0);
	// keep two slots spare for the transaction in flight in the front stage
	assign room = (cnt_q <= (QAw+1)'(QDepth - 2));
	assign head = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QAw'(1);
			if (pop) rd_q <= rd_q + QAw'(1);
			cnt_q <= cnt_q + (QAw+1)'(push) - (QAw+1)'(pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	`CPIO_ASSERT_ALWAYS(a_no_ovf, !(push && !pop && cnt_q == (QAw+1)'(QDepth)), "queue overflow")
	`CPIO_ASSERT_ALWAYS(a_no_udf, !(pop && cnt_q == '0), "queue underflow")
	`CPIO_ASSERT_ALWAYS(a_cnt_rng, cnt_q <= (QAw+1)'(QDepth), "queue count out of range")
endmodule

// ----- design/cpio_back.sv -----
// ----------------------------------------------------------------------------
// cpio_back
// Output back end: presents queued result transactions on the port.
// ----------------------------------------------------------------------------
module cpio_back import cpio_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_not_empty,
	input  res_t        q_head,
	output logic        q_pop,
	output logic        valid,
	input  logic        stall,
	output logic [1:0]  kind,
	output logic [7:0]  byte_value,
	output logic [31:0] file_mode,
	output logic [31:0] owner_id,
	output logic [31:0] group_id,
	output logic [31:0] data_length,
	output logic [31:0] name_length,
	output logic        keep_entry,
	output logic        bad_header,
	output logic        run_last
);
	res_t out_q;
	logic load;

	// load the output register when it is empty or being drained
	assign load  = q_not_empty && (!valid || !stall);
	assign q_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (load) begin
			valid <= 1'b1;
		end else if (!stall) begin
			valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) out_q <= q_head;
	end

	assign kind        = out_q.kind;
	assign byte_value  = out_q.byte_value;
	assign file_mode   = out_q.file_mode;
	assign owner_id    = out_q.owner_id;
	assign group_id    = out_q.group_id;
	assign data_length = out_q.data_length;
	assign name_length = out_q.name_length;
	assign keep_entry  = out_q.keep_entry;
	assign bad_header  = out_q.bad_header;
	assign run_last    = out_q.run_last;
endmodule

// ----- design/cpio_newc_stream_parser_unit.sv -----
// ----------------------------------------------------------------------------
// cpio_newc_stream_parser_unit
// Byte-serial cpio newc archive parser with decoupled output queue.
// ----------------------------------------------------------------------------
// One archive byte is taken per clock while the result queue has room; each
// byte yields at most one result transaction (name byte, entry record, data
// byte or archive end), passed through the front output stage and the queue
// to the output register, held while the output is stalled. Throughput is one
// byte per cycle while the queue has room, set by the per-byte phase and hex
// accumulator update in the front; the four-entry queue absorbs output stalls.
module cpio_newc_stream_parser_unit import cpio_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  byte_value,
	output logic [31:0] file_mode,
	output logic [31:0] owner_id,
	output logic [31:0] group_id,
	output logic [31:0] data_length,
	output logic [31:0] name_length,
	output logic        keep_entry,
	output logic        bad_header,
	output logic        run_last
);
	logic take, res_valid, q_ne, q_room, q_pop;
	res_t res, q_head;

	assign in_stall = !q_room;
	assign take = in_valid && q_room;

	cpio_front u_front (
		.clk, .arst_n, .take, .data_byte, .final_byte, .res_valid, .res
	);

	cpio_queue u_queue (
		.clk, .arst_n, .push(res_valid), .push_data(res), .pop(q_pop),
		.not_empty(q_ne), .room(q_room), .head(q_head)
	);

	cpio_back u_back (
		.clk, .arst_n, .q_not_empty(q_ne), .q_head, .q_pop,
		.valid(out_valid), .stall(out_stall), .kind, .byte_value, .file_mode,
		.owner_id, .group_id, .data_length, .name_length, .keep_entry,
		.bad_header, .run_last
	);
endmodule
